/* src/noet_pkg.sv */
// shared types and constants for the node index table with oldest-entry eviction
// no dependencies; used by the controller, datapath and top level
package noet_pkg;

  // field widths
  localparam int OP_W       = 2;
  localparam int KEY_W      = 32;
  localparam int TIME_W     = 32;
  localparam int SEL_W      = 6;
  localparam int PL_W       = 2;
  localparam int CNT_W      = 7;
  localparam int INTERVAL_W = 31;

  // default table size
  localparam int SLOTS_DEF = 64;

  // repost interval after reset, in milliseconds
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 31'd600000;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_QUERY = 2'd1,
    OP_MARK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // put placement codes
  localparam logic [PL_W-1:0] PL_UPDATE = 2'd0;
  localparam logic [PL_W-1:0] PL_FILL   = 2'd1;
  localparam logic [PL_W-1:0] PL_EVICT  = 2'd2;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SWEEP_ALL,
    CMD_SWEEP_POST,
    CMD_SCAN,
    CMD_PUT_WRITE,
    CMD_READ_SEL,
    CMD_MARK
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    cmd_t cmd;
    logic report;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic idx_last;
  } status_t;

endpackage

/* src/noet_ram.sv */
// generic single-port ram with registered read
// no dependencies
module noet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/noet_ctrl.sv */
// controller state machine: sequences the clearing pass, scans, writes and reports
// depends on noet_pkg
module noet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  noet_pkg::status_t status,
  output noet_pkg::ctrl_t   ctrl,
  output logic              busy
);

  import noet_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_TAIL,
    S_PUT_WR,
    S_DUE,
    S_TCLR
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next  = state;
    ctrl.cmd    = CMD_NONE;
    ctrl.report = 1'b0;
    unique case (state)
      S_INIT: begin
        ctrl.cmd = CMD_SWEEP_ALL;
        if (status.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl.cmd   = CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.op)
          OP_PUT: begin
            state_next = S_SCAN;
          end
          OP_QUERY: begin
            ctrl.cmd   = CMD_READ_SEL;
            state_next = S_DUE;
          end
          OP_MARK: begin
            ctrl.cmd    = CMD_MARK;
            ctrl.report = 1'b1;
            state_next  = S_IDLE;
          end
          OP_CLEAR: begin
            state_next = S_TCLR;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        ctrl.cmd = CMD_SCAN;
        if (status.idx_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_PUT_WR;
      end
      S_PUT_WR: begin
        ctrl.cmd    = CMD_PUT_WRITE;
        ctrl.report = 1'b1;
        state_next  = S_IDLE;
      end
      S_DUE: begin
        ctrl.report = 1'b1;
        state_next  = S_IDLE;
      end
      S_TCLR: begin
        ctrl.cmd = CMD_SWEEP_POST;
        if (status.idx_last) begin
          ctrl.report = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* src/noet_dpath.sv */
// datapath: slot stores, scan accumulators, occupancy count, due check and result registers
// depends on noet_pkg and noet_ram
module noet_dpath #(
  parameter int SLOTS = noet_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  noet_pkg::ctrl_t                   ctrl,
  output noet_pkg::status_t                 status,
  input  logic [noet_pkg::OP_W-1:0]         opcode,
  input  logic [noet_pkg::KEY_W-1:0]        key_prefix,
  input  logic [noet_pkg::TIME_W-1:0]       advert_time,
  input  logic [noet_pkg::SEL_W-1:0]        slot_select,
  input  logic [noet_pkg::TIME_W-1:0]       now_time,
  input  logic                              cfg_we,
  input  logic [noet_pkg::INTERVAL_W-1:0]   cfg_wdata,
  output logic                              done,
  output logic [noet_pkg::SEL_W-1:0]        slot_out,
  output logic [noet_pkg::PL_W-1:0]         placement,
  output logic                              due,
  output logic [noet_pkg::CNT_W-1:0]        occupied_count
);

  import noet_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = (AW > SEL_W) ? AW : SEL_W;
  localparam int OW = (CW > CNT_W) ? CW : CNT_W;

  // captured transaction
  op_t                   op_q;
  logic [KEY_W-1:0]      key_q;
  logic [TIME_W-1:0]     adv_q;
  logic [SEL_W-1:0]      sel_q;
  logic [TIME_W-1:0]     now_q;
  logic [INTERVAL_W-1:0] interval;

  // sweep and scan control
  logic [AW-1:0] idx;
  logic          idx_last;
  logic          scan_vld;
  logic [AW-1:0] scan_idx;

  // scan results
  logic              match_found;
  logic [AW-1:0]     match_idx;
  logic              empty_found;
  logic [AW-1:0]     empty_idx;
  logic [TIME_W-1:0] min_adv;
  logic [AW-1:0]     min_idx;

  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;
  logic [CW-1:0] occ_dec;
  logic [CW-1:0] occ_evict;

  // ram ports
  logic [AW-1:0]     ram_addr;
  logic              key_we, adv_we, post_we;
  logic [KEY_W-1:0]  key_wd, key_rd;
  logic [TIME_W-1:0] adv_wd, adv_rd;
  logic [TIME_W-1:0] post_wd, post_rd;

  // put decision
  logic [AW-1:0]   put_slot;
  logic [PL_W-1:0] put_mode;
  logic            evict;

  logic [EW-1:0]     sel_ext;
  logic [AW-1:0]     sel_addr;
  logic              sel_in_range;
  logic [EW-1:0]     slot_ext;
  logic [OW-1:0]     occ_ext;
  logic [TIME_W-1:0] diff;
  logic              due_c;

  noet_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .addr(ram_addr), .wdata(key_wd), .rdata(key_rd)
  );

  noet_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_adv_ram (
    .clk(clk), .we(adv_we), .addr(ram_addr), .wdata(adv_wd), .rdata(adv_rd)
  );

  noet_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_post_ram (
    .clk(clk), .we(post_we), .addr(ram_addr), .wdata(post_wd), .rdata(post_rd)
  );

  // slot select mapping and range check
  assign sel_ext      = EW'(sel_q);
  assign sel_addr     = sel_ext[AW-1:0];
  assign sel_in_range = ({1'b0, sel_ext} < (EW+1)'(SLOTS));
  assign idx_last     = (idx == AW'(SLOTS - 1));

  assign status.op       = op_q;
  assign status.idx_last = idx_last;

  // eviction count: drop for the cleared slot, rise for the new entry
  assign occ_dec   = (occ != '0) ? occ - 1'b1 : occ;
  assign occ_evict = (occ_dec < CW'(SLOTS)) ? occ_dec + 1'b1 : occ_dec;

  // put placement: matching slot, else first empty slot, else oldest
  always_comb begin
    put_slot = min_idx;
    put_mode = PL_EVICT;
    evict    = 1'b0;
    occ_next = occ;
    priority if (match_found) begin
      put_slot = match_idx;
      put_mode = PL_UPDATE;
    end else if (occ < CW'(SLOTS) && empty_found) begin
      put_slot = empty_idx;
      put_mode = PL_FILL;
      occ_next = occ + 1'b1;
    end else begin
      evict    = 1'b1;
      occ_next = occ_evict;
    end
    if (ctrl.cmd != CMD_PUT_WRITE) begin
      occ_next = occ;
    end
  end

  // due check against the wrapped time difference
  assign diff  = now_q - post_rd;
  assign due_c = sel_in_range && (adv_rd != '0) &&
                 ((post_rd == '0) || (!diff[TIME_W-1] && (diff[INTERVAL_W-1:0] >= interval)));

  // ram address and writes
  always_comb begin
    unique case (ctrl.cmd)
      CMD_PUT_WRITE:             ram_addr = put_slot;
      CMD_READ_SEL, CMD_MARK:    ram_addr = sel_addr;
      default:                   ram_addr = idx;
    endcase
  end

  assign key_we  = (ctrl.cmd == CMD_SWEEP_ALL) || (ctrl.cmd == CMD_PUT_WRITE);
  assign adv_we  = key_we;
  assign key_wd  = (ctrl.cmd == CMD_PUT_WRITE) ? key_q : '0;
  assign adv_wd  = (ctrl.cmd == CMD_PUT_WRITE) ? adv_q : '0;
  assign post_we = (ctrl.cmd == CMD_SWEEP_ALL) || (ctrl.cmd == CMD_SWEEP_POST) ||
                   ((ctrl.cmd == CMD_PUT_WRITE) && evict) ||
                   ((ctrl.cmd == CMD_MARK) && sel_in_range);
  assign post_wd = (ctrl.cmd == CMD_MARK) ? now_q : '0;

  assign slot_ext = EW'(put_slot);
  assign occ_ext  = OW'(occ_next);

  // transaction capture
  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_LOAD) begin
      op_q  <= op_t'(opcode);
      key_q <= key_prefix;
      adv_q <= advert_time;
      sel_q <= slot_select;
      now_q <= now_time;
    end
  end

  // repost interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RST;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  // sweep and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= (ctrl.cmd == CMD_SCAN);
      if (ctrl.cmd == CMD_LOAD) begin
        idx <= '0;
      end else if (ctrl.cmd == CMD_SWEEP_ALL || ctrl.cmd == CMD_SWEEP_POST ||
                   ctrl.cmd == CMD_SCAN) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
    end
  end

  // scan accumulators, fed in the cycle after the read address is applied
  always_ff @(posedge clk) begin
    scan_idx <= idx;
    if (ctrl.cmd == CMD_LOAD) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else if (scan_vld) begin
      if (!match_found && (adv_rd != '0) && (key_rd == key_q)) begin
        match_found <= 1'b1;
        match_idx   <= scan_idx;
      end
      if (!empty_found && (adv_rd == '0)) begin
        empty_found <= 1'b1;
        empty_idx   <= scan_idx;
      end
      if ((scan_idx == '0) || (adv_rd < min_adv)) begin
        min_adv <= adv_rd;
        min_idx <= scan_idx;
      end
    end
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.report;
    end
    if (ctrl.report) begin
      slot_out       <= (op_q == OP_PUT) ? slot_ext[SEL_W-1:0] : sel_q;
      placement      <= (op_q == OP_PUT) ? put_mode : PL_UPDATE;
      due            <= (op_q == OP_QUERY) ? due_c : 1'b0;
      occupied_count <= occ_ext[CNT_W-1:0];
    end
  end

endmodule

/* src/node_index_oldest_evict_table_unit.sv */
// top level of the node index table with oldest-entry eviction
// depends on noet_pkg, noet_ctrl and noet_dpath
//
// A transaction is accepted when start is high and busy is low; its single result
// appears on slot_out, placement, due and occupied_count for one cycle with done
// high, and the receiver cannot stall it. Every slot store is walked through one
// single-port ram address per cycle, so a put scans all slots for a match, the first
// empty slot and the oldest advert, then does one write; a due query reads the
// selected slot, mark posted writes it, and clearing all post timers sweeps every
// slot. After reset a clearing pass zeroes the stores with busy high; repost
// interval writes on cfg_we are taken at any time.
module node_index_oldest_evict_table_unit #(
  parameter int SLOTS = noet_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [noet_pkg::OP_W-1:0]       opcode,
  input  logic [noet_pkg::KEY_W-1:0]      key_prefix,
  input  logic [noet_pkg::TIME_W-1:0]     advert_time,
  input  logic [noet_pkg::SEL_W-1:0]      slot_select,
  input  logic [noet_pkg::TIME_W-1:0]     now_time,
  input  logic                            cfg_we,
  input  logic [noet_pkg::INTERVAL_W-1:0] cfg_wdata,
  output logic                            done,
  output logic [noet_pkg::SEL_W-1:0]      slot_out,
  output logic [noet_pkg::PL_W-1:0]       placement,
  output logic                            due,
  output logic [noet_pkg::CNT_W-1:0]      occupied_count
);

  import noet_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  noet_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .ctrl(ctrl), .busy(busy)
  );

  noet_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk(clk), .rst(rst), .ctrl(ctrl), .status(status),
    .opcode(opcode), .key_prefix(key_prefix), .advert_time(advert_time),
    .slot_select(slot_select), .now_time(now_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .slot_out(slot_out), .placement(placement), .due(due),
    .occupied_count(occupied_count)
  );

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a report is issued only from the controller's final step of a transaction
  a_report_once: assert property (@(posedge clk) disable iff (rst)
    ctrl.report |=> !ctrl.report)
    else $error("two reports in consecutive cycles");

  // a due answer always comes with placement PL_UPDATE
  a_due_placement: assert property (@(posedge clk) disable iff (rst)
    (done && due) |-> (placement == PL_UPDATE))
    else $error("due answer with nonzero placement");

endmodule
